FILE: rtl/chtc_pkg.sv
// shared types and constants for the centerline half-tube cell classifier
package chtc_pkg;

   localparam int COORD_BITS     = 24;
   localparam int INDEX_BITS     = 6;
   localparam int COUNT_BITS     = 7;
   localparam int MODE_BITS      = 2;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = COORD_BITS;
   localparam int DEF_MAX_POINTS = 64;

   // difference of two coordinates, product of two differences, sum of three products
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;

   // configuration register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REMOVAL_MODE = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CAMERA_X     = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CAMERA_Y     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CAMERA_Z     = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_POINT_COUNT  = 3'd4;

   // removal modes
   localparam logic [MODE_BITS-1:0] CUT_NONE  = 2'd0;
   localparam logic [MODE_BITS-1:0] CUT_FRONT = 2'd1;
   localparam logic [MODE_BITS-1:0] CUT_BACK  = 2'd2;

   // item kinds
   localparam logic ITEM_LOAD     = 1'b0;
   localparam logic ITEM_CLASSIFY = 1'b1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic                         mode;
      logic [INDEX_BITS-1:0]        point_index;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic                  remove_cell;
      logic [INDEX_BITS-1:0] nearest_index;
   } rsp_type;

   // search result handed from the nearest-point unit to the top level
   typedef struct packed {
      logic                  done;
      logic [COUNT_BITS-1:0] index;
      point_type             point;
   } near_type;

endpackage

FILE: rtl/chtc_nearest.sv
// centerline point memory and nearest-point scan pipeline
module chtc_nearest
   import chtc_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_en,
   input  logic [INDEX_BITS-1:0] load_index,
   input  point_type             load_point,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] count,
   input  point_type             center,
   output near_type              result
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   point_type mem [MAX_POINTS];

   logic                  issuing_ff;
   logic [COUNT_BITS-1:0] issue_idx_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  issue_last_in;

   logic                  v1_ff, v2_ff, v3_ff;
   logic                  last1_ff, last2_ff, last3_ff;
   logic [COUNT_BITS-1:0] idx1_ff, idx2_ff, idx3_ff;
   point_type             rdata_ff, pt2_ff, pt3_ff;

   logic signed [DIFF_BITS-1:0] dx, dy, dz;
   logic signed [PROD_BITS-1:0] sqx, sqy, sqz;
   logic [PROD_BITS-1:0]        sq_ff [3];
   logic [SUM_BITS-1:0]         dist_ff;

   logic [SUM_BITS-1:0]   best_dist_ff;
   logic [COUNT_BITS-1:0] best_idx_ff;
   point_type             best_pt_ff;
   logic                  done_ff;

   logic wr_ok;

   assign wr_ok = load_en && (32'(load_index) < 32'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[AW'(load_index)] <= load_point;
      end
      rdata_ff <= mem[AW'(issue_idx_ff)];
   end

   assign issue_last_in = (COUNT_BITS'(issue_idx_ff + 1'b1) == count_ff);

   // address issue, one read per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff   <= 1'b0;
         issue_idx_ff <= '0;
         count_ff     <= '0;
      end else if (start) begin
         issuing_ff   <= 1'b1;
         issue_idx_ff <= '0;
         count_ff     <= count;
      end else if (issuing_ff) begin
         issue_idx_ff <= COUNT_BITS'(issue_idx_ff + 1'b1);
         if (issue_last_in) begin
            issuing_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      dx  = DIFF_BITS'(center.x) - DIFF_BITS'(rdata_ff.x);
      dy  = DIFF_BITS'(center.y) - DIFF_BITS'(rdata_ff.y);
      dz  = DIFF_BITS'(center.z) - DIFF_BITS'(rdata_ff.z);
      sqx = dx * dx;
      sqy = dy * dy;
      sqz = dz * dz;
   end

   // control tags of the scan pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= issuing_ff;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         done_ff <= v3_ff && last3_ff;
      end
   end

   // payload of the scan pipeline
   always_ff @(posedge clock) begin
      last1_ff <= issue_last_in;
      idx1_ff  <= issue_idx_ff;

      last2_ff <= last1_ff;
      idx2_ff  <= idx1_ff;
      pt2_ff   <= rdata_ff;
      sq_ff[0] <= unsigned'(sqx);
      sq_ff[1] <= unsigned'(sqy);
      sq_ff[2] <= unsigned'(sqz);

      last3_ff <= last2_ff;
      idx3_ff  <= idx2_ff;
      pt3_ff   <= pt2_ff;
      dist_ff  <= SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);

      // strict less keeps the lowest index on a tie
      if (v3_ff && ((idx3_ff == '0) || (dist_ff < best_dist_ff))) begin
         best_dist_ff <= dist_ff;
         best_idx_ff  <= idx3_ff;
         best_pt_ff   <= pt3_ff;
      end
   end

   assign result.done  = done_ff;
   assign result.index = best_idx_ff;
   assign result.point = best_pt_ff;

endmodule

FILE: rtl/centerline_half_tube_cell_classifier_core.sv
// top level: configuration registers, control sequencer, side test and result register
// a load transaction writes the point memory on acceptance; a classify transaction with
// points in use runs the nearest-point scan, then the dot, sum and finish states, and then
// fills the result register; with no points it goes straight to finish; no request is
// taken outside idle; the scan reads one stored point per cycle; loads one per idle cycle
// reset: synchronous, clears the sequencer and the result valid, removal mode to front,
// camera to zero and point count to zero; point memory contents stay undefined until loaded
module centerline_half_tube_cell_classifier_core
   import chtc_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CLAMP = (MAX_POINTS < 127) ? MAX_POINTS : 127;
   localparam logic [COUNT_BITS-1:0] CLAMP_N = COUNT_BITS'(CLAMP);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DOT,
      ST_SUM,
      ST_FINISH
   } state_type;

   state_type state_ff;

   logic [MODE_BITS-1:0]         removal_mode_ff;
   logic signed [COORD_BITS-1:0] camera_x_ff, camera_y_ff, camera_z_ff;
   logic [COUNT_BITS-1:0]        point_count_ff;

   logic [COUNT_BITS-1:0] used_n;
   logic                  req_accept;
   logic                  load_en;
   logic                  start;
   point_type             center_ff;
   point_type             load_point;
   near_type              near;
   logic                  empty_ff;

   logic signed [DIFF_BITS-1:0] ax, ay, az, bx, by, bz;
   logic signed [PROD_BITS-1:0] prod_ff [3];
   logic signed [SUM_BITS-1:0]  dot_ff;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_free;
   logic    dot_neg, dot_zero, remove;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         removal_mode_ff <= CUT_FRONT;
         camera_x_ff     <= '0;
         camera_y_ff     <= '0;
         camera_z_ff     <= '0;
         point_count_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REMOVAL_MODE: removal_mode_ff <= csr_wdata[MODE_BITS-1:0];
            CSR_CAMERA_X:     camera_x_ff     <= signed'(csr_wdata[COORD_BITS-1:0]);
            CSR_CAMERA_Y:     camera_y_ff     <= signed'(csr_wdata[COORD_BITS-1:0]);
            CSR_CAMERA_Z:     camera_z_ff     <= signed'(csr_wdata[COORD_BITS-1:0]);
            CSR_POINT_COUNT:  point_count_ff  <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign used_n     = (point_count_ff > CLAMP_N) ? CLAMP_N : point_count_ff;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_en    = req_accept && (req_data.mode == ITEM_LOAD);
   assign start      = req_accept && (req_data.mode == ITEM_CLASSIFY) && (used_n != '0);

   assign load_point.x = req_data.coord_x;
   assign load_point.y = req_data.coord_y;
   assign load_point.z = req_data.coord_z;

   chtc_nearest #(
      .MAX_POINTS(MAX_POINTS)
   ) u_nearest (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .load_index (req_data.point_index),
      .load_point (load_point),
      .start      (start),
      .count      (used_n),
      .center     (center_ff),
      .result     (near)
   );

   // (center - nearest) and (nearest - camera)
   always_comb begin
      ax = DIFF_BITS'(center_ff.x) - DIFF_BITS'(near.point.x);
      ay = DIFF_BITS'(center_ff.y) - DIFF_BITS'(near.point.y);
      az = DIFF_BITS'(center_ff.z) - DIFF_BITS'(near.point.z);
      bx = DIFF_BITS'(near.point.x) - DIFF_BITS'(camera_x_ff);
      by = DIFF_BITS'(near.point.y) - DIFF_BITS'(camera_y_ff);
      bz = DIFF_BITS'(near.point.z) - DIFF_BITS'(camera_z_ff);
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         center_ff <= load_point;
      end
      if (state_ff == ST_DOT) begin
         prod_ff[0] <= ax * bx;
         prod_ff[1] <= ay * by;
         prod_ff[2] <= az * bz;
      end
      if (state_ff == ST_SUM) begin
         dot_ff <= SUM_BITS'(prod_ff[0]) + SUM_BITS'(prod_ff[1]) + SUM_BITS'(prod_ff[2]);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign dot_neg  = dot_ff[SUM_BITS-1];
   assign dot_zero = (dot_ff == '0);
   assign remove   = !empty_ff &&
                     (((removal_mode_ff == CUT_FRONT) && dot_neg) ||
                      ((removal_mode_ff == CUT_BACK) && !dot_neg && !dot_zero));

   // result stays while stalled, a new one enters from the finish state
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         empty_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_data.mode == ITEM_CLASSIFY)) begin
                  if (used_n == '0) begin
                     empty_ff <= 1'b1;
                     state_ff <= ST_FINISH;
                  end else begin
                     empty_ff <= 1'b0;
                     state_ff <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               if (near.done) begin
                  state_ff <= ST_DOT;
               end
            end
            ST_DOT: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the result register is free
               if (out_free) begin
                  rsp_data_ff.remove_cell   <= remove;
                  rsp_data_ff.nearest_index <= empty_ff ? '0 : near.index[INDEX_BITS-1:0];
                  state_ff                  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
